// ===== src/pse_pkg.sv =====
// Shared types and constants for the positional sequence editor.
package pse_pkg;

   localparam int FUNC_W  = 3;
   localparam int POS_W   = 12;
   localparam int VALUE_W = 32;

   localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
   localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
   localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
   localparam logic [FUNC_W-1:0] FN_CHANGE = 3'd4;
   localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd5;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUERY,
      ST_SHIFT,
      ST_FLUSH,
      ST_PUT,
      ST_DONE
   } state_type;

endpackage

// ===== src/pse_ifs.sv =====
// Request and response channel interfaces of the positional sequence editor.
interface pse_req_if;
   logic                         valid;
   logic                         ready;
   logic [pse_pkg::FUNC_W-1:0]   func;
   logic [pse_pkg::POS_W-1:0]    position;
   logic signed [pse_pkg::VALUE_W-1:0] value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface pse_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic signed [pse_pkg::VALUE_W-1:0] read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink   (input valid, input status, input read_value, output ready);
endinterface

// ===== src/positional_sequence_editor.sv =====
// Ordered sequence store with append, insert, delete, change, query and clear.
// A request runs from idle to the done state: a query reads in ST_QUERY, an insert or
// delete that moves entries steps through ST_SHIFT and ST_FLUSH, and such an insert
// then writes its value in ST_PUT. One request at a time: no new request is taken until
// the response register takes the last result, and a shift moves one entry per cycle
// (one read, one write port). Reset clears the entry count and the control state;
// memory contents are left as they are.
module positional_sequence_editor #(
   parameter int DEPTH = 2048
) (
   input logic       clock,
   input logic       reset,
   pse_req_if.sink   req_if,
   pse_rsp_if.source rsp_if
);
   import pse_pkg::*;

   // Address, count and compare widths follow from DEPTH.
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // Sequencer state and the captured request.
   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [VALUE_W-1:0]     value_ff, value_in;

   // Shift engine: read pointer, end of run, direction, write-behind slot.
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          last_ff, last_in;
   logic                   up_ff, up_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pend_addr_ff, pend_addr_in;

   // Finished result, and the output register toward the response channel.
   logic                   res_status_ff, res_status_in;
   logic [VALUE_W-1:0]     res_value_ff, res_value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;

   // Entry memory: one write and one registered read per cycle.
   logic [VALUE_W-1:0]     entries_mem [DEPTH];
   logic [VALUE_W-1:0]     mem_rdata_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_W-1:0]     mem_wdata;

   // Request decode.
   logic                   req_fire;
   logic                   rsp_free;
   logic [CMPW-1:0]        pos_ext;
   logic [CMPW-1:0]        cnt_ext;
   logic [CW-1:0]          cnt_m1;
   logic                   not_full;
   logic                   pos_lt_cnt;
   logic                   pos_eq_cnt;
   logic                   pos_is_last;
   logic [AW-1:0]          req_addr;

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign req_fire          = req_if.valid && req_if.ready;
   assign rsp_free          = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.read_value = rsp_value_ff;

   always_comb begin
      pos_ext     = CMPW'(req_if.position);
      cnt_ext     = CMPW'(count_ff);
      cnt_m1      = count_ff - CW'(1);
      not_full    = (count_ff != CW'(DEPTH));
      pos_lt_cnt  = (pos_ext < cnt_ext);
      pos_eq_cnt  = (pos_ext == cnt_ext);
      // Only meaningful when the position lies inside the sequence.
      pos_is_last = (pos_ext == CMPW'(cnt_m1));
      req_addr    = pos_ext[AW-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_if.func == FN_QUERY && pos_lt_cnt) begin
                  state_in = ST_QUERY;
               end else if (req_if.func == FN_INSERT && pos_lt_cnt && not_full) begin
                  state_in = ST_SHIFT;
               end else if (req_if.func == FN_DELETE && pos_lt_cnt && !pos_is_last) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_QUERY: state_in = ST_DONE;
         ST_SHIFT: begin
            if (ptr_ff == last_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = up_ff ? ST_PUT : ST_DONE;
         ST_PUT:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      up_in         = up_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = mem_rdata_ff;
      mem_raddr     = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = req_addr;
            if (req_fire) begin
               pos_in        = req_addr;
               value_in      = req_if.value;
               pend_in       = 1'b0;
               res_status_in = STATUS_FAIL;
               res_value_in  = '0;
               unique case (req_if.func)
                  FN_CLEAR: begin
                     count_in      = '0;
                     res_status_in = STATUS_OK;
                  end
                  FN_APPEND: begin
                     if (not_full) begin
                        mem_we        = 1'b1;
                        mem_waddr     = cnt_m1[AW-1:0] + AW'(1);
                        mem_wdata     = req_if.value;
                        count_in      = count_ff + CW'(1);
                        res_status_in = STATUS_OK;
                     end
                  end
                  FN_INSERT: begin
                     if (not_full && (pos_lt_cnt || pos_eq_cnt)) begin
                        count_in      = count_ff + CW'(1);
                        res_status_in = STATUS_OK;
                        if (pos_eq_cnt) begin
                           // Insert at the end: plain append.
                           mem_we    = 1'b1;
                           mem_waddr = req_addr;
                           mem_wdata = req_if.value;
                        end else begin
                           // Move entries up, top first, then drop the value in.
                           ptr_in  = cnt_m1[AW-1:0];
                           last_in = req_addr;
                           up_in   = 1'b1;
                        end
                     end
                  end
                  FN_DELETE: begin
                     if (pos_lt_cnt) begin
                        count_in      = cnt_m1;
                        res_status_in = STATUS_OK;
                        // Move the later entries down, lowest first.
                        ptr_in  = req_addr + AW'(1);
                        last_in = cnt_m1[AW-1:0];
                        up_in   = 1'b0;
                     end
                  end
                  FN_CHANGE: begin
                     if (pos_lt_cnt) begin
                        mem_we        = 1'b1;
                        mem_waddr     = req_addr;
                        mem_wdata     = req_if.value;
                        res_status_in = STATUS_OK;
                     end
                  end
                  FN_QUERY: begin
                     if (pos_lt_cnt) begin
                        res_status_in = STATUS_OK;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_FAIL;
                  end
               endcase
            end
         end
         ST_QUERY: begin
            res_value_in = mem_rdata_ff;
         end
         ST_SHIFT: begin
            // Read at the pointer, and write the entry read in the previous cycle to its new slot.
            mem_raddr    = ptr_ff;
            mem_we       = pend_ff;
            mem_waddr    = pend_addr_ff;
            mem_wdata    = mem_rdata_ff;
            pend_in      = 1'b1;
            pend_addr_in = up_ff ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
            if (ptr_ff != last_ff) begin
               ptr_in = up_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
            end
         end
         ST_FLUSH: begin
            // Write the last entry still in flight.
            mem_we    = 1'b1;
            mem_waddr = pend_addr_ff;
            mem_wdata = mem_rdata_ff;
            pend_in   = 1'b0;
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = value_ff;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      last_ff       <= last_in;
      up_ff         <= up_in;
      pend_addr_ff  <= pend_addr_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= entries_mem[mem_raddr];
   end

   // The count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   // Writes never land past the slot just after the last entry.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) <= count_ff))
      else $error("memory write past end of sequence");

   // The final write-behind always has a read in flight.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> pend_ff)
      else $error("flush without pending entry");

   // A response appears only when the result stage hands it over.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside result handoff");

   // A held response keeps its payload until taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> $stable(rsp_value_ff) && $stable(rsp_status_ff))
      else $error("response payload changed while stalled");

endmodule

// ===== verif/positional_sequence_editor_tb.sv =====
// Self-checking testbench for the positional sequence editor.
`timescale 1ns / 100ps

module positional_sequence_editor_tb;
   import pse_pkg::*;

   localparam int DEPTH = 2048;

   // Function codes the block does not define; both must be rejected.
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

   localparam logic [POS_W-1:0]          POS_TOP   = '1;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   localparam int RANDOM_REQUESTS = 263;
   localparam int MAX_IDLE        = 15;
   localparam int MAX_REPORTS     = 10;

   // Worst case per request: a full shift plus the longest gap on each side.
   // Budget covers the directed and random requests, three times over.
   localparam int REQUEST_BUDGET = 400;
   localparam int CYCLE_LIMIT    = 3 * REQUEST_BUDGET * (DEPTH + 4 + 2 * (MAX_IDLE + 1));

   // One outcome per request; func and position are kept for mismatch reports.
   typedef struct {
      logic [FUNC_W-1:0]          func;
      logic [POS_W-1:0]           position;
      logic                       status;
      logic signed [VALUE_W-1:0]  read_value;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   pse_req_if req_ch ();
   pse_rsp_if rsp_ch ();

   positional_sequence_editor #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow copy of the stored sequence and the outcomes still owed by the block.
   logic signed [VALUE_W-1:0] shadow_list[$];
   outcome_type               pending_outcomes[$];

   int          error_count = 0;
   int unsigned cycle_count = 0;
   bit          no_idle     = 1'b0;   // set for back-to-back stretches on both sides

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("positional_sequence_editor_tb: errors");
         $finish;
      end
   end

   // Apply one command to the shadow list and return the outcome it must produce.
   function automatic outcome_type apply_to_shadow(input logic [FUNC_W-1:0] fn,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [VALUE_W-1:0] val);
      outcome_type res;
      int unsigned count;
      int unsigned idx;
      count          = shadow_list.size();
      idx            = 32'(pos);
      res.func       = fn;
      res.position   = pos;
      res.status     = STATUS_FAIL;
      res.read_value = '0;
      case (fn)
         FN_CLEAR: begin
            shadow_list.delete();
            res.status = STATUS_OK;
         end
         FN_APPEND: begin
            if (count < DEPTH) begin
               shadow_list.insert(shadow_list.size(), val);
               res.status = STATUS_OK;
            end
         end
         FN_INSERT: begin
            // Insert at the count is an append; past the count or when full it is refused.
            if (idx <= count && count < DEPTH) begin
               shadow_list.insert(idx, val);
               res.status = STATUS_OK;
            end
         end
         FN_DELETE: begin
            if (idx < count) begin
               shadow_list.delete(idx);
               res.status = STATUS_OK;
            end
         end
         FN_CHANGE: begin
            if (idx < count) begin
               shadow_list[idx] = val;
               res.status = STATUS_OK;
            end
         end
         FN_QUERY: begin
            // A query at the count is out of range, not a read past the end.
            if (idx < count) begin
               res.read_value = shadow_list[idx];
               res.status     = STATUS_OK;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%s", msg);
   endtask

   // Present one request after a random gap and hold it until the block takes it.
   // Valid stays high on return so a zero gap gives back-to-back requests.
   task automatic send_request(input logic [FUNC_W-1:0] fn,
                               input logic [POS_W-1:0] pos,
                               input logic signed [VALUE_W-1:0] val);
      int          gap;
      outcome_type owed;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= fn;
      req_ch.position <= pos;
      req_ch.value    <= val;
      do @(posedge clock); while (!req_ch.ready);
      owed = apply_to_shadow(fn, pos, val);
      pending_outcomes.insert(pending_outcomes.size(), owed);
   endtask

   // Mostly in range or right at the edge, sometimes anywhere in the field.
   function automatic logic [POS_W-1:0] pick_position(input int unsigned count);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15)
         return POS_W'($urandom_range(0, POS_TOP));
      if (roll < 25)
         return POS_W'(count);
      return POS_W'($urandom_range(0, count));
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Commands on an empty store: everything positional is out of range.
   task automatic test_empty_store();
      send_request(FN_QUERY,    POS_W'(0), '0);
      send_request(FN_DELETE,   POS_W'(0), '0);
      send_request(FN_CHANGE,   POS_W'(0), 32'sh0000_0001);
      send_request(FN_INSERT,   POS_W'(1), 32'sh0000_0002);
      send_request(FN_SPARE_LO, POS_W'(0), VALUE_MAX);
      send_request(FN_SPARE_HI, POS_TOP, VALUE_MIN);
   endtask

   // Every function once, value extremes, and the range edges on a short list.
   task automatic test_basic_edits();
      send_request(FN_APPEND, POS_W'(0), VALUE_MIN);
      send_request(FN_APPEND, POS_W'(0), VALUE_MAX);
      send_request(FN_APPEND, POS_W'(0), '0);
      send_request(FN_INSERT, POS_W'(1), '1);                  // shift up in the middle
      send_request(FN_INSERT, POS_W'(4), 32'sh5A5A_A5A5);      // position equals count
      send_request(FN_INSERT, POS_W'(6), 32'sh1111_1111);      // past the end
      send_request(FN_QUERY,  POS_W'(0), '0);
      send_request(FN_QUERY,  POS_W'(4), '0);
      send_request(FN_QUERY,  POS_W'(5), '0);                  // at the count
      send_request(FN_CHANGE, POS_W'(2), 32'sh0F0F_F0F0);
      send_request(FN_QUERY,  POS_W'(2), '0);
      send_request(FN_DELETE, POS_W'(0), '0);                  // shift down everything
      send_request(FN_DELETE, POS_W'(3), '0);                  // last entry
      send_request(FN_QUERY,  POS_W'(1), '0);
      send_request(FN_QUERY,  POS_TOP, '0);
      send_request(FN_DELETE, POS_TOP, '0);
      send_request(FN_CHANGE, POS_TOP, 32'shFFFF_0000);
      send_request(FN_CLEAR,  POS_W'(0), '0);
      send_request(FN_QUERY,  POS_W'(0), '0);                  // old contents no longer valid
      send_request(FN_APPEND, POS_W'(0), 32'sh1234_5678);
      send_request(FN_QUERY,  POS_W'(0), '0);
   endtask

   // Random edits. The list length hovers below about fifty so shifts stay short;
   // the occasional clear and the back-to-back stretches vary the timing.
   task automatic test_random_edits();
      int unsigned               roll;
      int unsigned               count;
      logic [FUNC_W-1:0]         fn;
      logic signed [VALUE_W-1:0] val;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         count = shadow_list.size();
         roll  = $urandom_range(0, 99);
         if (roll < 2)
            fn = FN_CLEAR;
         else if (roll < 4)
            fn = roll[0] ? FN_SPARE_LO : FN_SPARE_HI;
         else if (roll < 22)
            fn = (count > 48) ? FN_DELETE : FN_APPEND;
         else if (roll < 40)
            fn = (count > 48) ? FN_DELETE : FN_INSERT;
         else if (roll < 55)
            fn = FN_DELETE;
         else if (roll < 70)
            fn = FN_CHANGE;
         else
            fn = FN_QUERY;
         // Value is random even where it is ignored.
         val = pick_value();
         send_request(fn, pick_position(count), val);
      end
      no_idle = 1'b0;
   endtask

   // Response side: draw a stall, then take one response and check it against
   // the oldest outcome owed.
   initial begin : response_checker
      int          stall;
      outcome_type want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         if (pending_outcomes.size() == 0) begin
            note_failure($sformatf("unexpected response: status %0b value %0d",
                                   rsp_ch.status, rsp_ch.read_value));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value)
               note_failure($sformatf(
                  "mismatch func %0d pos %0d: expected status %0b value %0d, got %0b %0d",
                  want.func, want.position, want.status, want.read_value,
                  rsp_ch.status, rsp_ch.read_value));
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.func     <= FN_CLEAR;
      req_ch.position <= '0;
      req_ch.value    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_basic_edits();
      test_random_edits();

      // Drop valid, drain what is owed, then give a stray response time to show up.
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("positional_sequence_editor_tb: clean");
      end else begin
         $display("positional_sequence_editor_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pse_pkg.sv
src/pse_ifs.sv
src/positional_sequence_editor.sv
verif/positional_sequence_editor_tb.sv
